// ----- src/gwm_pkg.sv -----
// Shared types and constants of the glob wildcard matcher.
`timescale 1ns / 1ps
`default_nettype none

package gwm_pkg;

    // Item action codes
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_SUBJECT = 2'd1;
    localparam logic [1:0] ACT_QUERY   = 2'd2;

    // Wildcard bytes
    localparam logic [7:0] GLOB_ANY = 8'h2A;
    localparam logic [7:0] GLOB_ONE = 8'h3F;

    // Per-position set-up, from the cell's place, the pattern length and the write beat
    typedef struct packed {
        logic in_use;   // position lies below the pattern length
        logic at_end;   // position equals the pattern length
        logic is_head;  // position zero
        logic wr_en;    // pattern byte written into this cell this beat
    } gwm_pos_t;

    // Broadcast to every cell for the accepted beat
    typedef struct packed {
        logic       step;       // subject byte accepted
        logic       rearm;      // subject ends or query accepted this beat
        logic       query_sel;  // empty-subject query
        logic [7:0] subj_byte;
    } gwm_ctrl_t;

    // Handed from one cell to the next
    typedef struct packed {
        logic star_carry;  // active set extended across a star
        logic advance;     // position reached by consuming this byte
        logic tail_carry;  // closure of the updated set across a star
    } gwm_link_t;

endpackage

`default_nettype wire

// ----- src/gwm_cell.sv -----
// One pattern position: stored byte, active bit and its link logic.
`timescale 1ns / 1ps
`default_nettype none

module gwm_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire gwm_pkg::gwm_pos_t  pos,
    input  wire gwm_pkg::gwm_ctrl_t ctrl,
    input  wire logic [7:0]        wr_byte,
    input  wire gwm_pkg::gwm_link_t link_in,
    output gwm_pkg::gwm_link_t      link_out,
    output logic                   active,
    output logic                   end_hit
);

    logic [7:0] pat_reg;
    logic       act_reg;
    logic       act_next;

    logic is_star;
    logic is_one_hit;
    logic closed;
    logic hit_star;
    logic hit_adv;
    logic step_bit;
    logic tail_bit;
    logic tail_closed;

    // Pattern byte store
    always_ff @(posedge aclk) begin
        if (pos.wr_en) begin
            pat_reg <= wr_byte;
        end
    end

    // Match terms for this position
    always_comb begin
        is_star    = (pat_reg == gwm_pkg::GLOB_ANY);
        is_one_hit = (pat_reg == gwm_pkg::GLOB_ONE) || (pat_reg == ctrl.subj_byte);
        closed     = act_reg | link_in.star_carry;
        hit_star   = closed & pos.in_use & is_star;
        hit_adv    = closed & pos.in_use & ~is_star & is_one_hit;
        step_bit   = hit_star | link_in.advance;
        // closure of the updated set, or of the head alone for a query
        tail_bit    = ctrl.query_sel ? pos.is_head : step_bit;
        tail_closed = tail_bit | link_in.tail_carry;

        link_out.star_carry = hit_star;
        link_out.advance    = hit_adv;
        link_out.tail_carry = tail_closed & pos.in_use & is_star;
        end_hit             = tail_closed & pos.at_end;
    end

    // Active bit update
    always_comb begin
        act_next = act_reg;
        if (ctrl.rearm) begin
            act_next = pos.is_head;
        end else if (ctrl.step) begin
            act_next = step_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= pos.is_head;
        end else begin
            act_reg <= act_next;
        end
    end

    assign active = act_reg;

endmodule

`default_nettype wire

// ----- src/gwm_out_skid.sv -----
// Two-slot result buffer between the cell row and the result channel.
`timescale 1ns / 1ps
`default_nettype none

module gwm_out_skid (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire logic push_matched,
    output logic      full,
    output logic      m_valid,
    input  wire logic m_ready,
    output logic      m_matched
);

    logic head_v_reg, head_v_next;
    logic head_d_reg, head_d_next;
    logic tail_v_reg, tail_v_next;
    logic tail_d_reg, tail_d_next;
    logic pop;

    // Slot movement
    always_comb begin
        pop         = head_v_reg & m_ready;
        head_v_next = head_v_reg;
        head_d_next = head_d_reg;
        tail_v_next = tail_v_reg;
        tail_d_next = tail_d_reg;
        if (pop) begin
            if (tail_v_reg) begin
                head_d_next = tail_d_reg;
                tail_v_next = push;
                tail_d_next = push_matched;
            end else begin
                head_v_next = push;
                head_d_next = push_matched;
            end
        end else if (!head_v_reg) begin
            head_v_next = push;
            head_d_next = push_matched;
        end else if (push) begin
            tail_v_next = 1'b1;
            tail_d_next = push_matched;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_v_reg <= 1'b0;
            tail_v_reg <= 1'b0;
        end else begin
            head_v_reg <= head_v_next;
            tail_v_reg <= tail_v_next;
        end
        head_d_reg <= head_d_next;
        tail_d_reg <= tail_d_next;
    end

    assign full      = tail_v_reg;
    assign m_valid   = head_v_reg;
    assign m_matched = head_d_reg;

    // Checks
    a_tail_needs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_v_reg |-> head_v_reg)
        else $error("skid slot occupied with empty head");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("result pushed into full buffer");

endmodule

`default_nettype wire

// ----- src/glob_wildcard_matcher_core.sv -----
// Top level of the glob wildcard matcher: cell row, control and result buffer.
`timescale 1ns / 1ps
`default_nettype none

// Whole-string glob matcher with '*' and '?'. Load beats write pattern bytes;
// subject beats then stream in at one per clock while s_ready is high, and
// each final byte or empty-subject query pushes one result beat into the
// two-slot result buffer. The active-position update for a byte, including
// the star closure on both sides of it, ripples combinationally through the
// row of PATTERN_MAX cells. s_ready falls only while both result slots are full.
// A pattern entry must be written before a subject reads it.
module glob_wildcard_matcher_core #(
    parameter int PATTERN_MAX = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_action,
    input  wire logic [4:0] s_position,
    input  wire logic [7:0] s_byte_value,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_matched
);

    localparam logic [PATTERN_MAX:0] HEAD_ONLY = (PATTERN_MAX + 1)'(1);

    logic [5:0]          pattern_length_reg;
    logic                tail_act_reg, tail_act_next;
    logic                s_acc;
    logic                full;
    logic                tail_step;
    logic                tail_closed;
    logic                result_bit;
    logic [PATTERN_MAX:0] active_vec;
    logic [PATTERN_MAX:0] end_hits;

    gwm_pkg::gwm_ctrl_t  ctrl;
    gwm_pkg::gwm_link_t  link [PATTERN_MAX+1];
    gwm_pkg::gwm_pos_t   pos  [PATTERN_MAX];

    // Length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
        end else if (cfg_wr_en) begin
            pattern_length_reg <= cfg_wr_data;
        end
    end

    // Beat decode
    assign s_ready = ~full;
    assign s_acc   = s_valid & s_ready;

    always_comb begin
        ctrl.step      = s_acc && (s_action == gwm_pkg::ACT_SUBJECT);
        ctrl.query_sel = (s_action == gwm_pkg::ACT_QUERY);
        ctrl.rearm     = s_acc && (ctrl.query_sel ||
                         ((s_action == gwm_pkg::ACT_SUBJECT) && s_last));
        ctrl.subj_byte = s_byte_value;
    end

    assign link[0] = '0;

    // Cell row
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        always_comb begin
            pos[i].in_use  = int'(pattern_length_reg) > i;
            pos[i].at_end  = int'(pattern_length_reg) == i;
            pos[i].is_head = (i == 0);
            pos[i].wr_en   = s_acc && (s_action == gwm_pkg::ACT_WRITE) &&
                             (int'(s_position) == i);
        end

        gwm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .pos      (pos[i]),
            .ctrl     (ctrl),
            .wr_byte  (s_byte_value),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .active   (active_vec[i]),
            .end_hit  (end_hits[i])
        );
    end

    // Final position: no pattern byte, only the accept state
    always_comb begin
        tail_step   = link[PATTERN_MAX].advance;
        tail_closed = (~ctrl.query_sel & tail_step) | link[PATTERN_MAX].tail_carry;
        tail_act_next = tail_act_reg;
        if (ctrl.rearm) begin
            tail_act_next = 1'b0;
        end else if (ctrl.step) begin
            tail_act_next = tail_step;
        end
    end

    assign end_hits[PATTERN_MAX] = tail_closed & (int'(pattern_length_reg) >= PATTERN_MAX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_act_reg <= 1'b0;
        end else begin
            tail_act_reg <= tail_act_next;
        end
    end

    assign active_vec[PATTERN_MAX] = tail_act_reg;
    assign result_bit = |end_hits;

    // Result buffer
    gwm_out_skid u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (ctrl.rearm),
        .push_matched (result_bit),
        .full         (full),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_matched    (m_matched)
    );

    // Checks
    a_rearm_head_only: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rearm |=> (active_vec == HEAD_ONLY))
        else $error("active set not rearmed after subject end");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rearm |=> m_valid)
        else $error("result beat missing after subject end");

endmodule

`default_nettype wire
